/* hdl/ccr_pkg.sv */
// ----------------------------------------------------------------------------
// ccr_pkg - shared types and constants for the co-purchase count ranker
// Holds the table sizes, the beat layouts and the status codes that more
// than one file uses.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int ID_W       = 7;
  localparam int IDX_W      = 6;
  localparam int COUNT_BITS = 16;
  localparam int ADDR_W     = 2 * IDX_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADID = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] first_item;
    logic [ID_W-1:0] second_item;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]       item_id;
    logic [COUNT_BITS-1:0] pair_count;
    logic                  last;
    logic [1:0]            status;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [COUNT_BITS-1:0] cnt;
  } rank_t;

  // write request into the count table
  typedef struct packed {
    logic                  en;
    logic [ADDR_W-1:0]     addr;
    logic [COUNT_BITS-1:0] data;
  } wr_t;

endpackage

/* hdl/ccr_count_store.sv */
// ----------------------------------------------------------------------------
// ccr_count_store - co-occurrence count table
// One write port and one read port with registered read data, addressed
// as {row, column}.
// ----------------------------------------------------------------------------
module ccr_count_store
  import ccr_pkg::*;
(
  input  logic                  clk,
  input  wr_t                   wr,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [COUNT_BITS-1:0] rdata
);

  logic [COUNT_BITS-1:0] mem [MAX_ITEMS*MAX_ITEMS];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/copurchase_count_ranker.sv */
// ----------------------------------------------------------------------------
// copurchase_count_ranker - co-occurrence count table with ranked row query
// Records item pairs into a symmetric saturating count table and returns a
// queried item's row sorted by count, ascending.
// ----------------------------------------------------------------------------
// After reset the block clears all 4096 entries of the count table and
// stalls its input meanwhile; configuration writes are taken at any time.
// One beat is handled at a time. A record does two table read-modify-writes
// (the entry and its mirror) and then emits, or one read-modify-write and
// the emit when both ids match; errors go straight to the emit.
// A query of n items in use copies the row into the rank buffer item by
// item, then runs one exchange-sort pass per output position, one compare
// at a time on the rank buffer's single read port, each pass emitting its
// result as it closes. The output register lets the last result wait
// while the next beat is accepted.
module copurchase_count_ranker
  import ccr_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_t             in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_t            out_data,
  input  logic            cfg_we,
  input  logic [ID_W-1:0] cfg_data
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_R_RD1   = 4'd2;
  localparam logic [3:0] S_R_WR1   = 4'd3;
  localparam logic [3:0] S_R_RD2   = 4'd4;
  localparam logic [3:0] S_R_WR2   = 4'd5;
  localparam logic [3:0] S_RESP    = 4'd6;
  localparam logic [3:0] S_FILL_RD = 4'd7;
  localparam logic [3:0] S_FILL_WR = 4'd8;
  localparam logic [3:0] S_SORT_LD = 4'd9;
  localparam logic [3:0] S_SORT_LW = 4'd10;
  localparam logic [3:0] S_SORT_RD = 4'd11;
  localparam logic [3:0] S_SORT_CM = 4'd12;
  localparam logic [3:0] S_EMIT    = 4'd13;

  logic [3:0]            state;
  logic [ID_W-1:0]       items_in_use;
  logic [ADDR_W-1:0]     clr_addr;
  logic [IDX_W-1:0]      ra;
  logic [IDX_W-1:0]      cb;
  logic [ID_W-1:0]       n_q;
  logic [ID_W-1:0]       i;
  logic [ID_W-1:0]       j;
  rank_t                 cur;
  logic [COUNT_BITS-1:0] resp_cnt;
  logic [1:0]            resp_st;

  logic [ID_W-1:0]       n_eff;
  logic                  a_ok;
  logic                  b_ok;
  logic                  out_free;
  logic                  emit;
  logic                  accept;
  wr_t                   twr;
  logic [ADDR_W-1:0]     traddr;
  logic [COUNT_BITS-1:0] trdata;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sat;

  rank_t                 rank_mem [MAX_ITEMS];
  rank_t                 rank_rdata;
  logic                  rank_we;
  logic [IDX_W-1:0]      rank_waddr;
  rank_t                 rank_wdata;
  logic [IDX_W-1:0]      rank_raddr;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      items_in_use <= '0;
    end else if (cfg_we) begin
      items_in_use <= cfg_data;
    end
  end

  assign n_eff = (items_in_use > ID_W'(MAX_ITEMS)) ? ID_W'(MAX_ITEMS) : items_in_use;
  assign a_ok  = (in_data.first_item != '0) && (in_data.first_item <= n_eff);
  assign b_ok  = (in_data.second_item != '0) && (in_data.second_item <= n_eff);

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign emit     = out_free && ((state == S_EMIT) || (state == S_RESP));

  // saturating increment, two on the diagonal
  assign sum = {1'b0, trdata} + ((ra == cb && state == S_R_WR1) ? (COUNT_BITS+1)'(2)
                                                                 : (COUNT_BITS+1)'(1));
  assign sat = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];

  // count table port steering
  always_comb begin
    twr.en   = 1'b0;
    twr.addr = {ra, cb};
    twr.data = sat;
    traddr   = {ra, cb};
    unique case (state)
      S_CLEAR: begin
        twr.en   = 1'b1;
        twr.addr = clr_addr;
        twr.data = '0;
      end
      S_R_WR1: twr.en = 1'b1;
      S_R_RD2: traddr = {cb, ra};
      S_R_WR2: begin
        twr.en   = 1'b1;
        twr.addr = {cb, ra};
      end
      S_FILL_RD: traddr = {ra, i[IDX_W-1:0]};
      default: ;
    endcase
  end

  ccr_count_store u_store (
    .clk   (clk),
    .wr    (twr),
    .raddr (traddr),
    .rdata (trdata)
  );

  // rank buffer port steering
  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = i[IDX_W-1:0];
    rank_wdata = cur;
    rank_raddr = j[IDX_W-1:0];
    unique case (state)
      S_FILL_WR: begin
        rank_we    = 1'b1;
        rank_wdata = '{id: i + ID_W'(1), cnt: trdata};
      end
      S_SORT_CM: begin
        rank_we    = (cur.cnt > rank_rdata.cnt);
        rank_waddr = j[IDX_W-1:0];
      end
      S_SORT_LD: rank_raddr = i[IDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rdata <= rank_mem[rank_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            ra       <= IDX_W'(in_data.first_item - ID_W'(1));
            cb       <= IDX_W'(in_data.second_item - ID_W'(1));
            n_q      <= n_eff;
            i        <= '0;
            resp_cnt <= '0;
            if (in_data.op == OP_RECORD) begin
              if (a_ok && b_ok) begin
                state <= S_R_RD1;
              end else begin
                resp_st <= ST_BADID;
                state   <= S_RESP;
              end
            end else if (n_eff == '0) begin
              resp_st <= ST_EMPTY;
              state   <= S_RESP;
            end else if (!a_ok) begin
              resp_st <= ST_BADID;
              state   <= S_RESP;
            end else begin
              state <= S_FILL_RD;
            end
          end
        end
        S_R_RD1: state <= S_R_WR1;
        S_R_WR1: begin
          resp_cnt <= sat;
          resp_st  <= ST_OK;
          state    <= (ra == cb) ? S_RESP : S_R_RD2;
        end
        S_R_RD2: state <= S_R_WR2;
        S_R_WR2: state <= S_RESP;
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_FILL_RD: state <= S_FILL_WR;
        S_FILL_WR: begin
          if (i + ID_W'(1) == n_q) begin
            i     <= '0;
            state <= S_SORT_LD;
          end else begin
            i     <= i + ID_W'(1);
            state <= S_FILL_RD;
          end
        end
        S_SORT_LD: state <= S_SORT_LW;
        S_SORT_LW: begin
          cur   <= rank_rdata;
          j     <= i + ID_W'(1);
          state <= (i + ID_W'(1) == n_q) ? S_EMIT : S_SORT_RD;
        end
        S_SORT_RD: state <= S_SORT_CM;
        S_SORT_CM: begin
          if (cur.cnt > rank_rdata.cnt) begin
            cur <= rank_rdata;
          end
          j     <= j + ID_W'(1);
          state <= (j + ID_W'(1) == n_q) ? S_EMIT : S_SORT_RD;
        end
        S_EMIT: begin
          if (out_free) begin
            i     <= i + ID_W'(1);
            state <= (i + ID_W'(1) == n_q) ? S_IDLE : S_SORT_LD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (state == S_EMIT) begin
        out_data <= '{item_id: cur.id, pair_count: cur.cnt,
                      last: (i + ID_W'(1) == n_q), status: ST_OK};
      end else begin
        out_data <= '{item_id: '0, pair_count: resp_cnt, last: 1'b1, status: resp_st};
      end
    end
  end

  // checks
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input accepted twice in a row");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result during table clear");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    rank_we |-> (ID_W'(rank_waddr) < n_q))
    else $error("rank write beyond row length");

  a_err_id: assert property (@(posedge clk) disable iff (rst)
    (emit && state == S_RESP) |=> (out_data.item_id == '0 && out_data.last))
    else $error("response beat malformed");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the co-purchase count ranker
// Drives record and query beats with random idling on both channels, keeps
// its own copy of the count table and register, predicts every result beat
// and checks each delivered beat in order against the predicted ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import ccr_pkg::*;
();

  // scoreboard: predicted results of the count table
  class ranker_scoreboard;
    logic [COUNT_BITS-1:0] counts [MAX_ITEMS*MAX_ITEMS];
    logic [ID_W-1:0]       in_use;
    out_t                  pending [$];
    int                    errors;
    int                    shown;

    function new();
      foreach (counts[k]) counts[k] = '0;
      in_use  = '0;
      errors  = 0;
      shown   = 0;
    endfunction

    function void set_in_use(logic [ID_W-1:0] v);
      in_use = v;
    endfunction

    function logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c, int step);
      int unsigned s;
      s = c + step;
      return (s > COUNT_MAX) ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    function void push_beat(logic [ID_W-1:0] id, logic [COUNT_BITS-1:0] c,
                            logic lst, logic [1:0] st);
      out_t r;
      r.item_id    = id;
      r.pair_count = c;
      r.last       = lst;
      r.status     = st;
      pending.insert(pending.size(), r);
    endfunction

    // work out the results of one accepted input beat
    function void note_input(in_t b);
      int n, ra, cb, i, j;
      rank_t row [MAX_ITEMS];
      rank_t t;
      n = (in_use > MAX_ITEMS) ? MAX_ITEMS : in_use;
      if (b.op == OP_RECORD) begin
        if (b.first_item == 0 || b.first_item > n || b.second_item == 0 ||
            b.second_item > n) begin
          push_beat('0, '0, 1'b1, ST_BADID);
          return;
        end
        ra = b.first_item - 1;
        cb = b.second_item - 1;
        if (ra == cb) begin
          counts[ra*MAX_ITEMS+cb] = sat_inc(counts[ra*MAX_ITEMS+cb], 2);
        end else begin
          counts[ra*MAX_ITEMS+cb] = sat_inc(counts[ra*MAX_ITEMS+cb], 1);
          counts[cb*MAX_ITEMS+ra] = sat_inc(counts[cb*MAX_ITEMS+ra], 1);
        end
        push_beat('0, counts[ra*MAX_ITEMS+cb], 1'b1, ST_OK);
        return;
      end
      if (n == 0) begin
        push_beat('0, '0, 1'b1, ST_EMPTY);
        return;
      end
      if (b.first_item == 0 || b.first_item > n) begin
        push_beat('0, '0, 1'b1, ST_BADID);
        return;
      end
      ra = b.first_item - 1;
      for (i = 0; i < n; i++) begin
        row[i].id  = ID_W'(i + 1);
        row[i].cnt = counts[ra*MAX_ITEMS+i];
      end
      // exchange sort, swap when the earlier count is larger
      for (i = 0; i < n; i++)
        for (j = i + 1; j < n; j++)
          if (row[i].cnt > row[j].cnt) begin
            t = row[i]; row[i] = row[j]; row[j] = t;
          end
      for (i = 0; i < n; i++)
        push_beat(row[i].id, row[i].cnt, (i + 1 == n), ST_OK);
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result beat %p", got);
        end
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected id %0d cnt %0d last %0b st %0d,",
                   exp_r.item_id, exp_r.pair_count, exp_r.last, exp_r.status,
                   " got id %0d cnt %0d last %0b st %0d",
                   got.item_id, got.pair_count, got.last, got.status);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [ID_W-1:0] cfg_data = '0;

  ranker_scoreboard sb = new();
  bit   quiet      = 1'b0;   // no idling near the end
  bit   hold_req   = 1'b0;   // ask for one long receiver hold-off
  bit   hold_taken = 1'b0;
  int   hold_off   = 0;      // long receiver hold-off, in cycles

  always #10 clk = ~clk;

  copurchase_count_ranker i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // hold-off counter
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_off   <= 200;
    end else if (hold_off > 0) begin
      hold_off   <= hold_off - 1;
    end
  end

  // result side: check accepted beats, stall in bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_off > 0) begin
      out_stall  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // send one input beat, with an optional idle burst first
  task automatic send_beat(in_t b);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b);
  endtask

  task automatic send_op(logic op, logic [ID_W-1:0] a, logic [ID_W-1:0] c);
    in_t b;
    b.op = op; b.first_item = a; b.second_item = c;
    send_beat(b);
  endtask

  // let every predicted result arrive, then allow the block to settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_in_use(logic [ID_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_in_use(v);
  endtask

  // mostly well-formed records within the table, some queries and noise
  task automatic random_beat(int n);
    logic [ID_W-1:0] a, c;
    int r;
    r = $urandom_range(0, 99);
    if (n > 0) begin
      a = ID_W'($urandom_range(1, n));
      c = (r < 40) ? a : ID_W'($urandom_range(1, n));
    end else begin
      a = ID_W'($urandom_range(0, 127));
      c = ID_W'($urandom_range(0, 127));
    end
    if (r >= 92) begin
      a = ID_W'($urandom_range(0, 127));
      c = ID_W'($urandom_range(0, 127));
    end
    if (r >= 75 && r < 92) send_op(OP_QUERY, a, ID_W'($urandom_range(0, 127)));
    else send_op((r >= 97) ? OP_QUERY : OP_RECORD, a, c);
  endtask

  // at the full size queries are slow, so favour records there
  task automatic random_beat_rec(int n);
    send_op(OP_RECORD, ID_W'($urandom_range(1, n)), ID_W'($urandom_range(1, n)));
  endtask

  initial begin
    int k, n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, bad ids, extremes
    send_op(OP_QUERY, 7'd1, 7'd0);
    send_op(OP_RECORD, 7'd1, 7'd1);
    write_in_use(7'd64);
    send_op(OP_RECORD, 7'd1, 7'd64);
    send_op(OP_RECORD, 7'd64, 7'd64);
    send_op(OP_RECORD, 7'd0, 7'd5);
    send_op(OP_RECORD, 7'd5, 7'd65);
    send_op(OP_RECORD, 7'd127, 7'd127);
    send_op(OP_QUERY, 7'd0, 7'd0);
    send_op(OP_QUERY, 7'd127, 7'd127);
    send_op(OP_QUERY, 7'd64, 7'd3);
    send_op(OP_QUERY, 7'd1, 7'd127);
    // register above the table size acts as the full size
    write_in_use(7'd127);
    send_op(OP_RECORD, 7'd2, 7'd3);
    send_op(OP_QUERY, 7'd2, 7'd0);
    // shrink, then raise again: kept counts reappear
    write_in_use(7'd2);
    send_op(OP_RECORD, 7'd3, 7'd2);
    send_op(OP_QUERY, 7'd2, 7'd0);
    write_in_use(7'd3);
    send_op(OP_QUERY, 7'd3, 7'd0);
    write_in_use(7'd1);
    send_op(OP_RECORD, 7'd1, 7'd1);
    send_op(OP_QUERY, 7'd1, 7'd0);
    write_in_use(7'd0);
    send_op(OP_RECORD, 7'd0, 7'd0);

    // receiver holds off while the sender keeps offering
    write_in_use(7'd4);
    hold_req = 1'b1;
    for (k = 0; k < 12; k++) random_beat(4);
    // sender pauses until every result has come
    drain();

    // random phases over several table sizes
    for (k = 0; k < 330; k++) begin
      if (k % 55 == 0) begin
        case ((k / 55) % 6)
          0: n = 3;
          1: n = 8;
          2: n = 2;
          3: n = 64;
          4: n = 5;
          default: n = $urandom_range(1, 12);
        endcase
        write_in_use(ID_W'(n));
      end
      if (k >= 290) quiet = 1'b1;
      if (n == 64 && $urandom_range(0, 7) != 0) random_beat_rec(n);
      else random_beat(n);
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #(20 * 2000000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* copurchase_count_ranker.f */
hdl/ccr_pkg.sv
hdl/ccr_count_store.sv
hdl/copurchase_count_ranker.sv
bench/testbench.sv
